// File: design/urx_pkg.sv
`default_nettype none
package urx_pkg;

   localparam int PACKET_WORDS = 4;
   localparam int IDX_W        = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int WORD_W       = 32;
   localparam int EVENT_W      = 3;
   localparam int INDEX_W      = 3;

   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_1 = 8'h31;
   localparam logic [7:0] CHAR_3 = 8'h33;
   localparam logic [7:0] CHAR_4 = 8'h34;
   localparam logic [7:0] CHAR_5 = 8'h35;

   localparam logic [7:0] ZEROS_RESET = 8'd12;

   typedef enum logic [EVENT_W-1:0] {
      EV_LOCKED = 3'd0,
      EV_UNLOCK = 3'd1,
      EV_STORED = 3'd2,
      EV_GOOD   = 3'd3,
      EV_BAD    = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      MATCH_NONE,
      MATCH_3,
      MATCH_5,
      MATCH_1,
      MATCH_4,
      MATCH_0
   } match_type;

   // One classified transaction handed from the front end to the back end.
   typedef struct packed {
      event_type               ev;
      logic [WORD_W-1:0]       word;
      logic [IDX_W-1:0]        idx;
   } cmd_type;

endpackage
`default_nettype wire

// File: design/urx_front.sv
`default_nettype none
module urx_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [31:0]           req_rx_word,
   input  wire                   csr_we,
   input  wire  [7:0]            csr_wdata,
   output logic                  cmd_valid,
   output urx_pkg::cmd_type      cmd,
   input  wire                   cmd_full
);
   import urx_pkg::*;

   logic              unlocked_ff, unlocked_in;
   match_type         stage_ff, stage_in;
   logic [7:0]        run_ff, run_in;
   logic [7:0]        zeros_ff;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [15:0]       xor_ff, xor_in;
   logic [15:0]       xor_new;
   logic [7:0]        rx_byte;
   logic              hit;
   logic              fire;

   assign req_ready = !cmd_full;
   assign fire      = req_valid && req_ready;
   assign cmd_valid = fire;
   assign rx_byte   = req_rx_word[7:0];
   assign xor_new   = xor_ff ^ req_rx_word[15:0] ^ req_rx_word[31:16];

   always_comb begin
      stage_in    = stage_ff;
      run_in      = run_ff;
      unlocked_in = unlocked_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      hit         = 1'b0;
      cmd.ev      = EV_LOCKED;
      cmd.word    = '0;
      cmd.idx     = '0;
      if (!unlocked_ff) begin
         unique case (rx_byte)
            CHAR_3: stage_in = MATCH_3;
            CHAR_5: stage_in = (stage_ff == MATCH_3) ? MATCH_5 : MATCH_NONE;
            CHAR_1: stage_in = (stage_ff == MATCH_5) ? MATCH_1 : MATCH_NONE;
            CHAR_4: begin
               if (stage_ff == MATCH_1) begin
                  stage_in = MATCH_4;
                  run_in   = '0;
               end else begin
                  stage_in = MATCH_NONE;
               end
            end
            CHAR_0: begin
               if (stage_ff == MATCH_4 || stage_ff == MATCH_0) begin
                  stage_in = MATCH_0;
                  run_in   = run_ff + 8'd1;
                  hit      = (run_in == zeros_ff);
               end else begin
                  stage_in = MATCH_NONE;
               end
            end
            default: stage_in = MATCH_NONE;
         endcase
         if (hit) begin
            cmd.ev      = EV_UNLOCK;
            unlocked_in = 1'b1;
            count_in    = '0;
            xor_in      = '0;
         end
      end else begin
         cmd.word = req_rx_word;
         cmd.idx  = count_ff;
         if (count_ff == IDX_W'(PACKET_WORDS - 1)) begin
            cmd.ev   = (xor_new == 16'd0) ? EV_GOOD : EV_BAD;
            count_in = '0;
            xor_in   = '0;
         end else begin
            cmd.ev   = EV_STORED;
            count_in = count_ff + IDX_W'(1);
            xor_in   = xor_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unlocked_ff <= 1'b0;
         stage_ff    <= MATCH_NONE;
         run_ff      <= '0;
         count_ff    <= '0;
         xor_ff      <= '0;
         zeros_ff    <= ZEROS_RESET;
      end else begin
         if (csr_we) begin
            zeros_ff <= csr_wdata;
         end
         if (fire) begin
            unlocked_ff <= unlocked_in;
            stage_ff    <= stage_in;
            run_ff      <= run_in;
            count_ff    <= count_in;
            xor_ff      <= xor_in;
         end
      end
   end

endmodule
`default_nettype wire

// File: design/urx_queue.sv
`default_nettype none
module urx_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  urx_pkg::cmd_type   push_cmd,
   output logic               full,
   input  wire                pop,
   output logic               not_empty,
   output urx_pkg::cmd_type   pop_cmd
);
   import urx_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic               do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - CNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

// File: design/urx_back.sv
`default_nettype none
module urx_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                cmd_valid,
   input  urx_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [2:0]         rsp_event_res,
   output logic [31:0]        rsp_packet_word,
   output logic [2:0]         rsp_word_index,
   output logic               rsp_last
);
   import urx_pkg::*;

   logic [WORD_W-1:0]  pkt_ff [PACKET_WORDS];
   logic               emit_ff, emit_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   event_type          ev_ff, ev_in;
   logic               valid_ff, valid_in;
   event_type          out_ev_ff, out_ev_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic [INDEX_W-1:0] out_idx_ff, out_idx_in;
   logic               out_last_ff, out_last_in;
   logic               load;
   logic               pkt_we;

   assign load            = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_event_res   = out_ev_ff;
   assign rsp_packet_word = out_word_ff;
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last        = out_last_ff;

   always_comb begin
      emit_in     = emit_ff;
      cnt_in      = cnt_ff;
      ev_in       = ev_ff;
      valid_in    = valid_ff;
      out_ev_in   = out_ev_ff;
      out_word_in = out_word_ff;
      out_idx_in  = out_idx_ff;
      out_last_in = out_last_ff;
      cmd_pop     = 1'b0;
      pkt_we      = 1'b0;
      if (load) begin
         valid_in = 1'b0;
         if (emit_ff) begin
            // replay the stored packet one word a cycle while rsp_ready allows
            valid_in    = 1'b1;
            out_ev_in   = ev_ff;
            out_word_in = pkt_ff[cnt_ff];
            out_idx_in  = INDEX_W'(cnt_ff);
            out_last_in = (cnt_ff == IDX_W'(PACKET_WORDS - 1));
            if (out_last_in) begin
               emit_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end else if (cmd_valid) begin
            cmd_pop = 1'b1;
            pkt_we  = (cmd.ev == EV_STORED || cmd.ev == EV_GOOD || cmd.ev == EV_BAD);
            if (cmd.ev == EV_GOOD || cmd.ev == EV_BAD) begin
               emit_in = 1'b1;
               cnt_in  = '0;
               ev_in   = cmd.ev;
            end else begin
               valid_in    = 1'b1;
               out_ev_in   = cmd.ev;
               out_word_in = cmd.word;
               out_idx_in  = INDEX_W'(cmd.idx);
               out_last_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_we) begin
         pkt_ff[cmd.idx] <= cmd.word;
      end
      out_ev_ff   <= out_ev_in;
      out_word_ff <= out_word_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      ev_ff       <= ev_in;
      cnt_ff      <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         emit_ff  <= emit_in;
      end
   end

endmodule
`default_nettype wire

// File: design/uart_unlock_and_packet_receiver.sv
// UART unlock detector and packet receiver.
// req channel: one received UART word per transaction (req_rx_word). While
//   locked only the low byte matters; the sequence "3514" plus a run of
//   csr-programmed '0' bytes (default 12) unlocks the block for good.
// rsp channel: result transactions with event code, packet word, word index
//   and last flag. Every req gives one rsp, except the word closing a packet,
//   which gives PACKET_WORDS rsps (good or checksum-error status).
// csr port: csr_we/csr_wdata write the zero-run length, no wait state.
// Path: a req passes through the queue, then the output register, before it
//   shows up on rsp; a packet-closing word sets the replay flag first.
// Throughput: one transaction per cycle for single-result words while rsp is
//   not stalled; a closing word occupies the back end until its replay ends,
//   bounded by the one read port of the packet buffer.
// Stall: when rsp_ready is low the output register holds, the back end stops
//   and the two-entry queue fills; req_ready drops only once it is full.
// Reset (synchronous): locked, no match, counters and checksum cleared,
//   queue empty, register back to 12. Packet buffer contents are undefined.
`default_nettype none
module uart_unlock_and_packet_receiver (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire  [31:0]  req_rx_word,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output logic [2:0]   rsp_event_res,
   output logic [31:0]  rsp_packet_word,
   output logic [2:0]   rsp_word_index,
   output logic         rsp_last,
   input  wire          csr_we,
   input  wire  [7:0]   csr_wdata
);
   import urx_pkg::*;

   cmd_type  fe_cmd;     // classified transaction from front end
   logic     fe_valid;
   cmd_type  q_cmd;      // head of queue
   logic     q_full;
   logic     q_valid;
   logic     q_pop;

   urx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_word (req_rx_word),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd_valid   (fe_valid),
      .cmd         (fe_cmd),
      .cmd_full    (q_full)
   );

   // decouples classification from result replay
   urx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_valid),
      .push_cmd  (fe_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_cmd   (q_cmd)
   );

   urx_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_valid),
      .cmd             (q_cmd),
      .cmd_pop         (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_packet_word (rsp_packet_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire

// File: tb/testbench.sv
module testbench;
   import urx_pkg::*;

   // Generous cycle budget for about 110 transactions, each with up to four
   // results behind a randomly stalling receiver.
   localparam int unsigned LIMIT_CYCLES = 20000;
   // Filler byte that matches none of the sequence characters.
   localparam logic [7:0] CHAR_FILL = 8'h58;

   // One expected result transaction.
   typedef struct {
      event_type   ev;
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
   } rx_result_type;

   // Tracks unlock detector and packet state, queues the results each
   // accepted word must produce, and checks results in order.
   class urx_tracker_type;
      logic [7:0]    zeros_req;
      bit            unlocked;
      match_type     stage;
      logic [7:0]    zero_run;
      int            fill;
      logic [31:0]   words [PACKET_WORDS];
      logic [15:0]   xsum;
      rx_result_type awaited[$];
      int unsigned   errors, checked, locked_bytes, good_packets, bad_packets;

      function new();
         zeros_req    = ZEROS_RESET;
         unlocked     = 0;
         stage        = MATCH_NONE;
         zero_run     = 8'd0;
         fill         = 0;
         xsum         = 16'd0;
         errors       = 0;
         checked      = 0;
         locked_bytes = 0;
         good_packets = 0;
         bad_packets  = 0;
      endfunction

      function void push(event_type ev, logic [31:0] w, int i, bit l);
         rx_result_type r;
         r.ev   = ev;
         r.word = w;
         r.idx  = 3'(i);
         r.last = l;
         awaited.push_back(r);
      endfunction

      // True when this low byte would finish the unlock sequence.
      function bit would_unlock(logic [7:0] c);
         logic [7:0] nxt;
         nxt = zero_run + 8'd1;
         return !unlocked && c == CHAR_0 && (stage == MATCH_4 || stage == MATCH_0)
                && nxt == zeros_req;
      endfunction

      // A word that brings the running half-word XOR to zero.
      function logic [31:0] closing_word();
         logic [15:0] h;
         h = 16'($urandom());
         return {h, h ^ xsum};
      endfunction

      function void take_word(logic [31:0] w);
         logic [7:0] c;
         bit         hit;
         event_type  ev;
         int         k;
         if (!unlocked) begin
            c   = w[7:0];
            hit = 0;
            case (c)
               CHAR_3: stage = MATCH_3;
               CHAR_5: stage = (stage == MATCH_3) ? MATCH_5 : MATCH_NONE;
               CHAR_1: stage = (stage == MATCH_5) ? MATCH_1 : MATCH_NONE;
               CHAR_4: begin
                  if (stage == MATCH_1) begin
                     stage    = MATCH_4;
                     zero_run = 8'd0;
                  end else
                     stage = MATCH_NONE;
               end
               CHAR_0: begin
                  if (stage == MATCH_4 || stage == MATCH_0) begin
                     stage    = MATCH_0;
                     zero_run = zero_run + 8'd1;   // wraps at 8 bits
                     hit      = (zero_run == zeros_req);
                  end else
                     stage = MATCH_NONE;
               end
               default: stage = MATCH_NONE;
            endcase
            locked_bytes++;
            if (hit) begin
               unlocked = 1;
               fill     = 0;
               xsum     = 16'd0;
               push(EV_UNLOCK, 32'd0, 0, 1'b1);
            end else
               push(EV_LOCKED, 32'd0, 0, 1'b1);
            return;
         end
         if (fill >= PACKET_WORDS)
            fill = 0;
         words[fill] = w;
         xsum = xsum ^ w[15:0] ^ w[31:16];
         fill++;
         if (fill < PACKET_WORDS) begin
            push(EV_STORED, w, fill - 1, 1'b1);
            return;
         end
         ev = (xsum == 16'd0) ? EV_GOOD : EV_BAD;
         if (ev == EV_GOOD)
            good_packets++;
         else
            bad_packets++;
         for (k = 0; k < PACKET_WORDS; k++)
            push(ev, words[k], k, k == PACKET_WORDS - 1);
         fill = 0;
         xsum = 16'd0;
      endfunction

      task report(string what);
         errors++;
         if (errors <= 50)
            $display("MISMATCH: %s", what);
      endtask

      task match_result(logic [2:0] ev, logic [31:0] w, logic [2:0] idx, logic l);
         rx_result_type e;
         checked++;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing pending: ev=%0d word=%h idx=%0d last=%b",
                             ev, w, idx, l));
            return;
         end
         e = awaited.pop_front();
         if (ev !== e.ev)
            report($sformatf("result %0d event %0d, want %0d", checked, ev, e.ev));
         if (w !== e.word)
            report($sformatf("result %0d word %h, want %h", checked, w, e.word));
         if (idx !== e.idx)
            report($sformatf("result %0d index %0d, want %0d", checked, idx, e.idx));
         if (l !== e.last)
            report($sformatf("result %0d last %b, want %b", checked, l, e.last));
      endtask
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [31:0] req_rx_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_packet_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last;
   logic        csr_we      = 1'b0;
   logic [7:0]  csr_wdata   = 8'd0;

   urx_tracker_type model = new();
   bit              calm  = 0;   // set during stretches where neither side idles
   int unsigned     cycles = 0;

   uart_unlock_and_packet_receiver DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_word     (req_rx_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_packet_word (rsp_packet_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock)
      cycles <= cycles + 1;

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycles < LIMIT_CYCLES)
         @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // Result side: check every accepted transaction, stall about a quarter
   // of the cycles unless in a calm stretch.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else begin
         if (rsp_valid && rsp_ready)
            model.match_result(rsp_event_res, rsp_packet_word, rsp_word_index, rsp_last);
         rsp_ready <= calm || ($urandom_range(99) >= 25);
      end
   end

   // Present one word, optionally after a random idle gap, and hold it
   // until accepted. Valid is left high so back-to-back words don't bubble.
   task automatic send_word(input logic [31:0] w);
      if (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 25);
      end
      req_valid   <= 1'b1;
      req_rx_word <= w;
      do @(posedge clock); while (!req_ready);
      model.take_word(w);
   endtask

   // Low byte as given, upper bytes random (they must be ignored while locked).
   function automatic logic [31:0] noisy(input logic [7:0] c);
      logic [31:0] w;
      w      = $urandom();
      w[7:0] = c;
      return w;
   endfunction

   // Locked-phase byte that never completes the unlock early.
   task automatic send_locked(input logic [7:0] c);
      if (model.would_unlock(c))
         c = CHAR_FILL;
      send_word(noisy(c));
   endtask

   // Wait for every pending result plus the output pipeline depth.
   task automatic settle();
      req_valid <= 1'b0;
      while (model.awaited.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_zeros(input logic [7:0] v);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      model.zeros_req = v;
   endtask

   function automatic logic [7:0] seq_char();
      case ($urandom_range(5))
         0: return CHAR_3;
         1: return CHAR_5;
         2: return CHAR_1;
         3: return CHAR_4;
         4: return CHAR_0;
         default: return 8'($urandom());
      endcase
   endfunction

   // Mostly "3514" plus a zero run that stops short (or is broken), the
   // rest loose sequence characters and random bytes.
   task automatic locked_burst(input int n);
      int sent, k, z;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(99) < 60) begin
            send_locked(CHAR_3);
            send_locked(($urandom_range(9) == 0) ? seq_char() : CHAR_5);
            send_locked(($urandom_range(9) == 0) ? seq_char() : CHAR_1);
            send_locked(($urandom_range(9) == 0) ? seq_char() : CHAR_4);
            z = $urandom_range(8);
            for (k = 0; k < z; k++)
               send_locked(CHAR_0);
            send_locked(seq_char());
            sent += 5 + z;
         end else begin
            send_locked(seq_char());
            sent++;
         end
      end
   endtask

   function automatic logic [31:0] packet_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int k, p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, locked, default run length: restarts on '3', breaks,
      // stray characters, extreme word values.
      send_word({24'h0, CHAR_3});
      send_word({24'h0, CHAR_5});
      send_word({24'h0, CHAR_3});            // restart mid-sequence
      send_word({24'h0, CHAR_5});
      send_word({24'h0, CHAR_1});
      send_word({24'h0, CHAR_4});
      send_word({24'hFFFFFF, CHAR_0});
      send_word({24'hA5A5A5, CHAR_0});
      send_word({24'h0, CHAR_3});            // restart during the zero run
      send_word({24'h0, CHAR_5});
      send_word({24'h0, CHAR_1});
      send_word({24'h0, CHAR_4});
      send_word({24'h0, CHAR_0});
      send_word(32'hFFFF_FF41);              // break
      send_word({24'h0, CHAR_0});            // zero with no prefix
      send_word({24'h0, CHAR_4});            // '4' out of order
      send_word({24'h0, CHAR_1});            // '1' out of order
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);

      // Random locked traffic under several run lengths, extremes included.
      write_zeros(8'd255);
      locked_burst(8);
      write_zeros(8'd1);
      locked_burst(8);
      write_zeros(8'($urandom_range(12, 2)));
      locked_burst(8);

      // Unlock: raise the register in the middle of a zero run; the run
      // keeps its count and completes at the new length.
      write_zeros(8'd4);
      send_word(noisy(CHAR_3));
      send_word(noisy(CHAR_5));
      send_word(noisy(CHAR_1));
      send_word(noisy(CHAR_4));
      for (k = 0; k < 3; k++)
         send_word(noisy(CHAR_0));
      write_zeros(8'd6);
      while (!model.unlocked)
         send_word(noisy(CHAR_0));

      // Directed packets: one with a zero checksum, one without.
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h1234_5678);
      send_word(model.closing_word());
      send_word(32'h0000_0001);
      send_word(32'h8000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'hA5A5_A5A4);

      // Random packets, about half closed with a matching checksum word;
      // packets from the third on run with no idling on either side.
      for (p = 0; p < 8; p++) begin
         calm = (p >= 2 && p < 8);
         for (k = 0; k < PACKET_WORDS; k++) begin
            if (k == PACKET_WORDS - 1 && $urandom_range(1) == 0)
               send_word(model.closing_word());
            else
               send_word(packet_word());
         end
      end
      calm = 0;
      // Leave a partial packet open at the end.
      send_word(packet_word());

      settle();
      repeat (8) @(posedge clock);
      $display("Ran %0d locked bytes through the unlock detector, run length changed mid-run",
               model.locked_bytes);
      $display("then %0d good and %0d bad packets; %0d results compared, %0d mismatches",
               model.good_packets, model.bad_packets, model.checked, model.errors);
      if (model.errors == 0 && model.awaited.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
